// ===== design/fsta_pkg.sv =====
// Shared types and constants for the flow steering table with ageing.
`timescale 1ns / 1ps

package fsta_pkg;

  localparam logic [2:0] MODE_UPDATE = 3'd0;
  localparam logic [2:0] MODE_LOOKUP = 3'd1;
  localparam logic [2:0] MODE_SWEEP  = 3'd2;
  localparam logic [2:0] MODE_PURGE  = 3'd3;
  localparam logic [2:0] MODE_FLUSH  = 3'd4;
  localparam logic [2:0] MODE_TICK   = 3'd5;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_AGEING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QCOUNT = 1'd1;

  localparam logic [19:0] AGEING_RESET = 20'd3000;
  localparam logic [8:0]  QCOUNT_RESET = 9'd1;

  typedef struct packed {
    logic        valid;
    logic [31:0] hash;
    logic [7:0]  queue;
    logic [31:0] stamp;
  } fsta_entry_t;

  typedef struct packed {
    logic occupied;
    logic hash_eq;
    logic queue_eq;
    logic expired;
  } fsta_flags_t;

endpackage

// ===== design/flow_steering_table_ageing.sv =====
// Top level of the flow steering table with ageing.
//
// Items arrive on the input channel (in_valid, in_stall) with mode, rx_hash,
// rx_queue and sender_detached, and each gives exactly one result on the
// output channel (out_valid, out_stall). A transfer happens when valid is
// high and stall is low. One item is worked on at a time; in_stall is high
// while it is in progress.
// Lookup, sweep, purge and an update that is not ignored walk every slot
// of the entry memory, one slot per cycle through a single read port and one
// compare unit. An update then goes through a commit step, which writes its
// entry if it matched or found a free slot. Flush clears the memory one slot
// per cycle. Tick, unused modes and an ignored update go straight to their
// result. The next transfer is taken no earlier than the cycle after the
// result is loaded into the output register. After reset a clearing pass
// runs through the memory; no item is taken during it. Time, the flow count
// and the registers return to their reset values. The configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready; it must be
// written only while idle, and the block itself does not enforce this.
// A finished result waits in the output register while out_stall is high;
// the next item may be taken meanwhile, but its result is held back.
`timescale 1ns / 1ps

module flow_steering_table_ageing import fsta_pkg::*; #(
  parameter int unsigned FLOW_SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            mode,
  input  logic [31:0]           rx_hash,
  input  logic [7:0]            rx_queue,
  input  logic                  sender_detached,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  hit,
  output logic [7:0]            found_queue,
  output logic                  created,
  output logic                  table_full,
  output logic [6:0]            removed_count,
  output logic [6:0]            flow_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(FLOW_SLOTS);
  localparam int unsigned CW = $clog2(FLOW_SLOTS + 1);
  localparam logic [AW:0]   LIMIT = (AW + 1)'(FLOW_SLOTS);
  localparam logic [AW-1:0] LAST  = AW'(FLOW_SLOTS - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]    state;
  logic [AW:0]   cnt;
  logic          rd_live;
  logic [AW-1:0] rd_idx;
  logic          flush_op;

  logic [2:0]    op;
  logic [31:0]   key;
  logic [7:0]    qsel;
  logic [31:0]   threshold;

  logic [31:0]   time_now;
  logic [CW-1:0] valid_total;
  logic [19:0]   ageing_ticks;
  logic [8:0]    queue_count;

  logic          match;
  logic [AW-1:0] match_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;

  logic          r_hit;
  logic [7:0]    r_fq;
  logic          r_created;
  logic          r_full;
  logic [CW-1:0] r_removed;

  logic          we;
  logic [AW-1:0] waddr;
  fsta_entry_t   wdata;
  fsta_entry_t   rdata;
  fsta_flags_t   flags;
  logic          remove;
  logic          ignore_update;
  logic          accept;
  logic          load_result;

  fsta_store #(
    .DEPTH (FLOW_SLOTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (rdata)
  );

  fsta_slot_unit u_slot (
    .entry     (rdata),
    .key       (key),
    .queue_sel (qsel),
    .threshold (threshold),
    .flags     (flags)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign ignore_update = (rx_hash == 32'd0) || (queue_count == 9'd1) || sender_detached;
  assign load_result = (state == S_FIN) && (!out_valid || !out_stall);

  assign remove = rd_live && (state == S_WALK) &&
                  (((op == MODE_SWEEP) && flags.expired) ||
                   ((op == MODE_PURGE) && flags.queue_eq));

  always_comb begin
    we    = 1'b0;
    waddr = cnt[AW-1:0];
    wdata = rdata;
    priority if (state == S_CLEAR) begin
      we    = 1'b1;
      wdata = '0;
    end else if (remove) begin
      we          = 1'b1;
      waddr       = rd_idx;
      wdata.valid = 1'b0;
    end else if ((state == S_COMMIT) && (match || free_found)) begin
      we          = 1'b1;
      waddr       = match ? match_idx : free_idx;
      wdata.valid = 1'b1;
      wdata.hash  = key;
      wdata.queue = qsel;
      wdata.stamp = time_now;
    end else begin
      we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      rd_live      <= 1'b0;
      flush_op     <= 1'b0;
      time_now     <= '0;
      valid_total  <= '0;
      ageing_ticks <= AGEING_RESET;
      queue_count  <= QCOUNT_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_AGEING: ageing_ticks <= cfg_data;
          CFG_QCOUNT: queue_count  <= cfg_data[8:0];
        endcase
      end

      if (load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt[AW-1:0] == LAST) begin
            state <= flush_op ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op         <= mode;
            key        <= rx_hash;
            qsel       <= rx_queue;
            threshold  <= time_now - 32'(ageing_ticks);
            cnt        <= '0;
            rd_live    <= 1'b0;
            flush_op   <= 1'b0;
            match      <= 1'b0;
            free_found <= 1'b0;
            r_hit      <= 1'b0;
            r_fq       <= '0;
            r_created  <= 1'b0;
            r_full     <= 1'b0;
            r_removed  <= '0;
            unique case (mode)
              MODE_UPDATE: state <= ignore_update ? S_FIN : S_WALK;
              MODE_LOOKUP, MODE_SWEEP, MODE_PURGE: state <= S_WALK;
              MODE_FLUSH: begin
                flush_op    <= 1'b1;
                r_removed   <= valid_total;
                valid_total <= '0;
                state       <= S_CLEAR;
              end
              MODE_TICK: begin
                time_now <= time_now + 32'd1;
                state    <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_WALK: begin
          if (cnt < LIMIT) begin
            cnt <= cnt + 1'b1;
          end
          rd_live <= (cnt < LIMIT);
          rd_idx  <= cnt[AW-1:0];
          if (rd_live) begin
            unique case (op)
              MODE_UPDATE: begin
                if (flags.hash_eq) begin
                  match     <= 1'b1;
                  match_idx <= rd_idx;
                end
                if (!flags.occupied && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= rd_idx;
                end
              end
              MODE_LOOKUP: begin
                if (flags.hash_eq) begin
                  r_hit <= 1'b1;
                  r_fq  <= rdata.queue;
                end
              end
              default: begin
                if (remove) begin
                  r_removed   <= r_removed + 1'b1;
                  valid_total <= valid_total - 1'b1;
                end
              end
            endcase
            if (rd_idx == LAST) begin
              state <= (op == MODE_UPDATE) ? S_COMMIT : S_FIN;
            end
          end
        end
        S_COMMIT: begin
          priority if (match) begin
            r_hit <= 1'b1;
          end else if (free_found) begin
            r_created   <= 1'b1;
            valid_total <= valid_total + 1'b1;
          end else begin
            r_full <= 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (load_result) begin
            hit           <= r_hit;
            found_queue   <= r_fq;
            created       <= r_created;
            table_full    <= r_full;
            removed_count <= 7'(r_removed);
            flow_total    <= 7'(valid_total);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/fsta_store.sv =====
// Flow entry memory with one write port and one registered read port.
`timescale 1ns / 1ps

module fsta_store import fsta_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  fsta_entry_t   wdata,
  input  logic [AW-1:0] raddr,
  output fsta_entry_t   rdata
);

  fsta_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fsta_slot_unit.sv =====
// Shared compare unit that classifies one stored entry per cycle.
`timescale 1ns / 1ps

module fsta_slot_unit import fsta_pkg::*; (
  input  fsta_entry_t entry,
  input  logic [31:0] key,
  input  logic [7:0]  queue_sel,
  input  logic [31:0] threshold,
  output fsta_flags_t flags
);

  logic [31:0] diff;

  assign diff = threshold - entry.stamp;

  always_comb begin
    flags.occupied = entry.valid;
    flags.hash_eq  = entry.valid && (entry.hash == key);
    flags.queue_eq = entry.valid && (entry.queue == queue_sel);
    flags.expired  = entry.valid && !diff[31];
  end

endmodule

// ===== tb/tb_flow_steering_table_ageing.sv =====
// Self-checking testbench for the flow steering table with ageing.
`timescale 1ns / 1ps

module tb_flow_steering_table_ageing;
  import fsta_pkg::*;

  localparam int          SLOTS       = 64;
  localparam int          POOL_SIZE   = 96;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [2:0]  MODE_SPARE6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] hash;
    logic [7:0]  queue;
    logic        detached;
  } flow_item_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] found_queue;
    logic       created;
    logic       table_full;
    logic [6:0] removed_count;
    logic [6:0] flow_total;
  } flow_result_t;

  class flow_table_scoreboard;
    bit           slot_used [SLOTS];
    logic [31:0]  slot_hash [SLOTS];
    logic [7:0]   slot_queue[SLOTS];
    logic [31:0]  slot_stamp[SLOTS];
    logic [31:0]  now_ticks;
    int           live_flows;
    logic [19:0]  ageing;
    logic [8:0]   queue_total;
    flow_result_t outcomes_due[$];
    int           errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      now_ticks   = '0;
      live_flows  = 0;
      ageing      = AGEING_RESET;
      queue_total = QCOUNT_RESET;
      errors      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_AGEING: ageing = data[19:0];
        CFG_QCOUNT: queue_total = data[8:0];
        default: ;
      endcase
    endfunction

    function int slot_of(logic [31:0] hash);
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_hash[i] == hash) return i;
      end
      return -1;
    endfunction

    function void note_item(flow_item_t it);
      flow_result_t r;
      int           slot;
      int           removed;
      logic [31:0]  expiry;
      logic [31:0]  gap;
      r = '0;
      removed = 0;
      case (it.mode)
        MODE_UPDATE: begin
          if (it.hash != '0 && queue_total != 9'd1 && !it.detached) begin
            slot = slot_of(it.hash);
            if (slot >= 0) begin
              r.hit = 1'b1;
              slot_queue[slot] = it.queue;
              slot_stamp[slot] = now_ticks;
            end else if (live_flows < SLOTS) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (!slot_used[i]) begin
                  slot_used[i]  = 1'b1;
                  slot_hash[i]  = it.hash;
                  slot_queue[i] = it.queue;
                  slot_stamp[i] = now_ticks;
                  live_flows++;
                  r.created = 1'b1;
                  break;
                end
              end
            end else begin
              r.table_full = 1'b1;
            end
          end
        end
        MODE_LOOKUP: begin
          slot = slot_of(it.hash);
          if (slot >= 0) begin
            r.hit = 1'b1;
            r.found_queue = slot_queue[slot];
          end
        end
        MODE_SWEEP: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
              expiry = slot_stamp[i] + {12'h000, ageing};
              gap = now_ticks - expiry;
              if (!gap[31]) begin
                slot_used[i] = 1'b0;
                live_flows--;
                removed++;
              end
            end
          end
        end
        MODE_PURGE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_queue[i] == it.queue) begin
              slot_used[i] = 1'b0;
              live_flows--;
              removed++;
            end
          end
        end
        MODE_FLUSH: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
              slot_used[i] = 1'b0;
              live_flows--;
              removed++;
            end
          end
        end
        MODE_TICK: now_ticks = now_ticks + 32'd1;
        default: ;
      endcase
      r.removed_count = removed[6:0];
      r.flow_total = live_flows[6:0];
      outcomes_due.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(flow_result_t got);
      flow_result_t want;
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("found_queue", want.found_queue, got.found_queue);
      compare_field("created", want.created, got.created);
      compare_field("table_full", want.table_full, got.table_full);
      compare_field("removed_count", want.removed_count, got.removed_count);
      compare_field("flow_total", want.flow_total, got.flow_total);
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst             = 1'b1;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [2:0]            mode            = '0;
  logic [31:0]           rx_hash         = '0;
  logic [7:0]            rx_queue        = '0;
  logic                  sender_detached = 1'b0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic                  hit;
  logic [7:0]            found_queue;
  logic                  created;
  logic                  table_full;
  logic [6:0]            removed_count;
  logic [6:0]            flow_total;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  logic                  hold_pending    = 1'b0;
  int                    tx_pct          = 15;
  int                    rx_pct          = 71;
  logic [31:0]           hash_pool[POOL_SIZE];
  flow_table_scoreboard  sb;

  flow_steering_table_ageing #(.FLOW_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .rx_hash(rx_hash), .rx_queue(rx_queue),
    .sender_detached(sender_detached),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .found_queue(found_queue), .created(created), .table_full(table_full),
    .removed_count(removed_count), .flow_total(flow_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result('{hit: hit, found_queue: found_queue, created: created,
                        table_full: table_full, removed_count: removed_count,
                        flow_total: flow_total});
    end
  end

  task automatic send_item(input logic [2:0] m, input logic [31:0] h, input logic [7:0] q,
                           input logic d);
    flow_item_t it;
    it = '{mode: m, hash: h, queue: q, detached: d};
    in_valid <= 1'b1;
    mode <= m;
    rx_hash <= h;
    rx_queue <= q;
    sender_detached <= d;
    @(posedge clk);
    while (in_stall) begin
      @(negedge clk);
      @(posedge clk);
    end
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(negedge clk);
      @(posedge clk);
    end
    sb.write_register(index, data);
    @(negedge clk);
  endtask

  task automatic write_settings(input logic [19:0] ageing_word, input logic [19:0] qcount_word);
    write_register(CFG_AGEING, ageing_word);
    write_register(CFG_QCOUNT, qcount_word);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [19:0] pick_ageing();
    case ($urandom_range(0, 6))
      0: return 20'd0;
      1: return 20'd1;
      2: return 20'hFFFFF;
      3: return 20'($urandom);
      default: return 20'($urandom_range(1, 30));
    endcase
  endfunction

  function automatic logic [19:0] pick_qcount();
    logic [8:0] q;
    case ($urandom_range(0, 7))
      0: q = 9'd0;
      1: q = 9'd1;
      2: q = 9'd2;
      3: q = 9'd256;
      4: q = 9'($urandom);
      default: q = 9'($urandom_range(2, 16));
    endcase
    return {11'($urandom), q};
  endfunction

  function automatic logic [31:0] pick_hash();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return hash_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 95) return $urandom;
    return 32'h0;
  endfunction

  function automatic logic [7:0] pick_queue();
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  task automatic send_random_item();
    int          r;
    logic [2:0]  m;
    r = $urandom_range(0, 99);
    if (r < 42)      m = MODE_UPDATE;
    else if (r < 64) m = MODE_LOOKUP;
    else if (r < 80) m = MODE_TICK;
    else if (r < 88) m = MODE_SWEEP;
    else if (r < 93) m = MODE_PURGE;
    else if (r < 95) m = MODE_FLUSH;
    else             m = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
    sender_gap();
    send_item(m, pick_hash(), pick_queue(), $urandom_range(0, 9) == 0);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: a single queue, so the update is ignored.
    send_item(MODE_UPDATE, 32'hDEADBEEF, 8'd3, 1'b0);
    send_item(MODE_LOOKUP, 32'h0, 8'd0, 1'b0);
    send_item(MODE_TICK, 32'h0, 8'd0, 1'b0);
    send_item(MODE_SPARE6, 32'h5A5A5A5A, 8'hA5, 1'b0);
    send_item(MODE_SPARE7, 32'hFFFFFFFF, 8'hFF, 1'b1);
    drain();
    write_settings(20'd2, 20'd4);
    send_item(MODE_UPDATE, 32'h0, 8'd1, 1'b0);
    send_item(MODE_UPDATE, 32'h80000000, 8'd1, 1'b1);
    send_item(MODE_UPDATE, 32'h80000000, 8'd255, 1'b0);
    send_item(MODE_UPDATE, 32'hFFFFFFFF, 8'd0, 1'b0);
    send_item(MODE_UPDATE, 32'h80000000, 8'd7, 1'b0);
    send_item(MODE_LOOKUP, 32'h80000000, 8'd0, 1'b0);
    send_item(MODE_LOOKUP, 32'hFFFFFFFF, 8'd0, 1'b0);
    send_item(MODE_LOOKUP, 32'h12345678, 8'd0, 1'b0);
    send_item(MODE_UPDATE, 32'h00000001, 8'd200, 1'b0);
    send_item(MODE_TICK, 32'h0, 8'd0, 1'b0);
    send_item(MODE_TICK, 32'h0, 8'd0, 1'b0);
    send_item(MODE_SWEEP, 32'h0, 8'd0, 1'b0);
    send_item(MODE_UPDATE, 32'h0000C0DE, 8'd5, 1'b0);
    send_item(MODE_UPDATE, 32'h0000D00D, 8'd5, 1'b0);
    send_item(MODE_UPDATE, 32'h0000E00E, 8'd6, 1'b0);
    send_item(MODE_PURGE, 32'h0, 8'd5, 1'b0);
    send_item(MODE_FLUSH, 32'h0, 8'd0, 1'b0);
    send_item(MODE_SWEEP, 32'h0, 8'd0, 1'b0);
    drain();
    // Zero queue count still lets updates through; zero ageing expires at once.
    write_settings(20'd0, {11'h7FF, 9'd0});
    send_item(MODE_UPDATE, 32'h00F00F00, 8'd9, 1'b0);
    send_item(MODE_SWEEP, 32'h0, 8'd0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      drain();
      tx_pct = (phase == 0) ? 15 : (phase == 1) ? 71 : 0;
      rx_pct <= (phase == 0) ? 71 : (phase == 1) ? 15 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        if (seg == 0) write_settings(pick_ageing(), {11'($urandom), 9'($urandom_range(2, 256))});
        else          write_settings(pick_ageing(), pick_qcount());
        foreach (hash_pool[i]) begin
          hash_pool[i] = $urandom;
          if (hash_pool[i] == 32'h0) hash_pool[i] = 32'h1;
        end
        if (phase == 0 && seg == 1) hold_pending <= 1'b1;
        if (seg == 0 || $urandom_range(0, 1) == 1) begin
          for (int k = 0; k < 66; k++) begin
            sender_gap();
            send_item(MODE_UPDATE, hash_pool[k], 8'($urandom_range(0, 7)), 1'b0);
          end
        end
        repeat (90) send_random_item();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/fsta_pkg.sv
design/fsta_store.sv
design/fsta_slot_unit.sv
design/flow_steering_table_ageing.sv
tb/tb_flow_steering_table_ageing.sv
